@@ rtl/core/lpm_pkg.sv @@
package lpm_pkg;

    localparam int TIME_W   = 32;
    localparam int LUX_W    = 16;
    localparam int DUTY_W   = 13;
    localparam int POWER_W  = 16;
    localparam int ENERGY_W = 64;
    localparam int VIS_W    = 24;
    localparam int FLK_W    = 22;
    localparam int FRAC_W   = 8;

    // Product widths of the two chained multiplies.
    localparam int PD_W   = POWER_W + DUTY_W;
    localparam int PROD_W = PD_W + TIME_W;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_POWER = 1'b0;
    localparam logic [POWER_W-1:0]   MAX_POWER_RESET = 16'd1000;

    typedef struct packed {
        logic [TIME_W-1:0] sample_time;
        logic [LUX_W-1:0]  target_lux;
        logic [LUX_W-1:0]  measured_lux;
        logic [DUTY_W-1:0] duty;
    } sample_word_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [VIS_W-1:0]    visibility;
        logic [FLK_W-1:0]    flicker;
    } metrics_word_t;

    typedef struct packed {
        logic load;
        logic mul_power;
        logic mul_time;
        logic commit;
    } lpm_cmd_t;

endpackage

@@ rtl/core/lighting_performance_metrics.sv @@
// Luminaire performance metrics. Each sample word (timestamp in ms, target and
// measured illuminance in 1/16 lux, LED duty) updates three running metrics and
// yields exactly one metrics word. Energy adds max_power times the duty of the
// previous sample times the elapsed time (timestamps wrap modulo 2^32) and
// sticks at all ones; divide it by the full-scale duty of 4096 to get mW*ms.
// Visibility is a halving average of the illuminance shortfall and flicker a
// halving average of the summed step sizes whenever the duty reverses
// direction; both carry 8 fraction bits and truncate. Duty is used as given,
// all 13 bits, with no clamping. From acceptance to the metrics word a sample
// goes through these steps in order: capture, the power-times-duty multiply,
// the multiply by elapsed time, and the fold of the product into the
// saturating energy sum with the update of the averages. The block then takes
// the next sample at once, but none while one is still in work; a metrics word
// left waiting holds the following sample in its last step until the word is
// taken. The only register, max_power, sits at byte address 0 of the APB port,
// resets to 1000 mW, and must be written only while the block is idle; writes
// to the word at byte address 4 are ignored and it reads as zero.
module lighting_performance_metrics (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  lpm_pkg::sample_word_t             sample,

    output logic                              metrics_valid,
    input  logic                              metrics_ready,
    output lpm_pkg::metrics_word_t            metrics,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lpm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lpm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import lpm_pkg::*;

    lpm_cmd_t           cmd;
    logic               cfg_hit;
    logic               cfg_we;
    logic [POWER_W-1:0] max_power;

    // The register index is the word address; the low two bits are the byte offset and are ignored.
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_MAX_POWER);
    assign cfg_we  = psel && penable && pwrite && cfg_hit;
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {{(APB_DATA_W - POWER_W){1'b0}}, max_power} : '0;

    lpm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .metrics_valid (metrics_valid),
        .metrics_ready (metrics_ready),
        .cmd           (cmd)
    );

    lpm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[POWER_W-1:0]),
        .max_power (max_power),
        .metrics   (metrics)
    );

endmodule

@@ rtl/core/lpm_ctrl.sv @@
module lpm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    output logic            sample_ready,
    output logic            metrics_valid,
    input  logic            metrics_ready,
    output lpm_pkg::lpm_cmd_t cmd
);
    import lpm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_POWER,
        S_MUL_TIME,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.load      = (state_reg == S_IDLE) && sample_valid;
        cmd.mul_power = (state_reg == S_MUL_POWER);
        cmd.mul_time  = (state_reg == S_MUL_TIME);
        // The metric state doubles as the output word, so it may only move
        // once the previous word has gone or is leaving at this edge.
        cmd.commit    = (state_reg == S_COMMIT) && (!out_valid_reg || metrics_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !metrics_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = S_MUL_POWER;
                end
            end
            S_MUL_POWER:
            begin
                state_next = S_MUL_TIME;
            end
            S_MUL_TIME:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sample_ready  = (state_reg == S_IDLE);
    assign metrics_valid = out_valid_reg;

endmodule

@@ rtl/core/lpm_dp.sv @@
module lpm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpm_pkg::lpm_cmd_t             cmd,
    input  lpm_pkg::sample_word_t         sample,
    input  logic                          cfg_we,
    input  logic [lpm_pkg::POWER_W-1:0]   cfg_wdata,
    output logic [lpm_pkg::POWER_W-1:0]   max_power,
    output lpm_pkg::metrics_word_t        metrics
);
    import lpm_pkg::*;

    // Architectural state.
    logic [POWER_W-1:0]  max_power_reg;
    logic [TIME_W-1:0]   last_time_reg;
    logic [DUTY_W-1:0]   duty_old_reg;
    logic [DUTY_W-1:0]   duty_new_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [VIS_W-1:0]    vis_reg;
    logic [FLK_W-1:0]    flk_reg;

    // Working registers of one sample.
    sample_word_t        sample_reg;
    logic [PD_W-1:0]     pd_reg;
    logic [TIME_W-1:0]   dt_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic [ENERGY_W:0]   energy_sum;
    logic [ENERGY_W-1:0] energy_next;
    logic [LUX_W-1:0]    shortfall;
    logic [VIS_W:0]      vis_sum;
    logic [VIS_W-1:0]    vis_next;
    logic                step_a_up;
    logic                step_a_down;
    logic                step_b_up;
    logic                step_b_down;
    logic [DUTY_W-1:0]   mag_a;
    logic [DUTY_W-1:0]   mag_b;
    logic [DUTY_W:0]     mag_sum;
    logic [FLK_W-1:0]    flk_term;
    logic [FLK_W:0]      flk_sum;
    logic [FLK_W-1:0]    flk_next;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
        end
        if (cmd.mul_power)
        begin
            pd_reg <= PD_W'(max_power_reg) * PD_W'(duty_new_reg);
            dt_reg <= sample_reg.sample_time - last_time_reg;
        end
        if (cmd.mul_time)
        begin
            prod_reg <= PROD_W'(pd_reg) * PROD_W'(dt_reg);
        end
    end

    always_comb
    begin
        energy_sum  = {1'b0, energy_reg} + {{(ENERGY_W + 1 - PROD_W){1'b0}}, prod_reg};
        energy_next = energy_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : energy_sum[ENERGY_W-1:0];

        shortfall = (sample_reg.target_lux > sample_reg.measured_lux)
                  ? sample_reg.target_lux - sample_reg.measured_lux : '0;
        vis_sum   = {1'b0, vis_reg} + {1'b0, shortfall, {FRAC_W{1'b0}}};
        vis_next  = vis_sum[VIS_W:1];

        step_a_up   = sample_reg.duty > duty_new_reg;
        step_a_down = sample_reg.duty < duty_new_reg;
        step_b_up   = duty_new_reg > duty_old_reg;
        step_b_down = duty_new_reg < duty_old_reg;
        mag_a = step_a_up ? sample_reg.duty - duty_new_reg : duty_new_reg - sample_reg.duty;
        mag_b = step_b_up ? duty_new_reg - duty_old_reg : duty_old_reg - duty_new_reg;
        mag_sum = {1'b0, mag_a} + {1'b0, mag_b};
        // Only a reversal of direction counts as flicker.
        flk_term = ((step_a_up && step_b_down) || (step_a_down && step_b_up))
                 ? {mag_sum, {FRAC_W{1'b0}}} : '0;
        flk_sum  = {1'b0, flk_reg} + {1'b0, flk_term};
        flk_next = flk_sum[FLK_W:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_power_reg <= MAX_POWER_RESET;
            last_time_reg <= '0;
            duty_old_reg  <= '0;
            duty_new_reg  <= '0;
            energy_reg    <= '0;
            vis_reg       <= '0;
            flk_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_power_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                last_time_reg <= sample_reg.sample_time;
                duty_old_reg  <= duty_new_reg;
                duty_new_reg  <= sample_reg.duty;
                energy_reg    <= energy_next;
                vis_reg       <= vis_next;
                flk_reg       <= flk_next;
            end
        end
    end

    assign max_power          = max_power_reg;
    assign metrics.energy     = energy_reg;
    assign metrics.visibility = vis_reg;
    assign metrics.flicker    = flk_reg;

endmodule

@@ rtl/core/lpm_checker.sv @@
module lpm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    input  logic                              sample_ready,
    input  logic                              metrics_valid,
    input  logic                              metrics_ready,
    input  lpm_pkg::metrics_word_t            metrics,
    input  logic                              pready
);
    import lpm_pkg::*;

    // No new sample is accepted while an accepted one is still in the datapath.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready ##1 !sample_ready ##1 !sample_ready)
        else $error("sample accepted while a previous one is still in work");

    // With no word pending, the word follows the multiply and commit states.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && !metrics_valid
        |=> !metrics_valid ##1 !metrics_valid ##1 !metrics_valid ##1 metrics_valid)
        else $error("metrics word did not arrive four cycles after the sample");

    // A waiting metrics word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        metrics_valid && !metrics_ready |=> metrics_valid && $stable(metrics))
        else $error("metrics word changed or dropped while stalled");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port inserted a wait state");

endmodule

bind lighting_performance_metrics lpm_checker u_lpm_checker (.*);
